/* hw/rtl/hnbs_pkg.sv */
// Shared types and constants of the HDLC NRZI bit stuffing transmitter.
package hnbs_pkg;

  // Command codes carried by the command word.
  typedef enum logic [1:0] {
    CMD_STUFFED = 2'd0,
    CMD_FLAG    = 2'd1,
    CMD_START   = 2'd2,
    CMD_FCS     = 2'd3
  } cmd_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_STUFF
  } state_e;

  // Control of the serial CRC unit for one cycle.
  typedef struct packed {
    logic init;
    logic shift;
    logic data;
  } crc_ctl_t;

  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [2:0]  RUN_MAX     = 3'd7;
  localparam logic [2:0]  STUFF_LIMIT = 3'd5;
  localparam logic [4:0]  BYTE_BITS   = 5'd8;
  localparam logic [4:0]  FCS_BITS    = 5'd16;

endpackage

/* hw/rtl/hnbs_if.sv */
// Handshake interfaces for the command and symbol channels.
interface hnbs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface hnbs_sym_if;
  logic valid;
  logic ready;
  logic tone;
  logic is_stuff;
  logic last;

  modport source (output valid, output tone, output is_stuff, output last, input ready);
  modport sink (input valid, input tone, input is_stuff, input last, output ready);
endinterface

/* hw/rtl/hnbs_crc.sv */
// Bit-serial reflected CRC-16 register with polynomial 0x8408.
module hnbs_crc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hnbs_pkg::crc_ctl_t ctl_i,
  output logic [15:0]       crc_o
);
  import hnbs_pkg::*;

  logic [15:0] crc_q;
  logic [15:0] crc_d;
  logic        fb;

  assign fb = crc_q[0] ^ ctl_i.data;

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.init) begin
      crc_d = CRC_INIT;
    end else if (ctl_i.shift) begin
      crc_d = (crc_q >> 1) ^ (fb ? CRC_POLY : 16'h0000);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

/* hw/rtl/hdlc_nrzi_bit_stuffing_transmitter.sv */
// Top level of the bit-serial HDLC transmitter with NRZI coding and bit stuffing.
//
// Each command word is either a byte to send (with or without bit stuffing), a
// frame start that sets the CRC to all ones, or a request to send the frame
// check sequence. Bytes leave LSB first through a 16-bit shift register, one
// line symbol per clock cycle into an output register, so the symbol channel
// sees at most one word per cycle. A data 1 keeps the line level and a data 0
// toggles it; after five ones in a row on a stuffed byte an extra toggle is
// sent, flagged by is_stuff and kept out of the CRC. The FCS command loads
// the complemented CRC as it stood when the command was taken and sends it
// low byte first, stuffed, so it yields 16 to 20 symbols. A command is taken
// only while the sequencer is idle: a byte is loaded and then yields 8 to 10
// symbols and a frame start sends none and leaves the sequencer idle, the
// symbols paced by the single symbol produced per cycle and stretched by any
// cycle in which the symbol sink holds ready low. The last symbol of each byte
// or FCS carries last.
module hdlc_nrzi_bit_stuffing_transmitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  hnbs_cmd_if.sink          cmd_i,
  hnbs_sym_if.source        sym_o
);
  import hnbs_pkg::*;

  state_e      state_q, state_d;
  logic [15:0] shreg_q, shreg_d;
  logic [4:0]  rem_q, rem_d;
  logic        stuffing_q, stuffing_d;
  logic [2:0]  ones_q, ones_d;
  logic        level_q, level_d;

  // Output register toward the symbol sink.
  logic        out_valid_q, out_valid_d;
  logic        tone_q, tone_d;
  logic        stuff_q, stuff_d;
  logic        last_q, last_d;

  logic        accept;
  logic        step;
  logic        bit_w;
  logic [2:0]  ones_inc;
  logic        need_stuff;
  logic [15:0] crc;
  crc_ctl_t    crc_ctl;

  hnbs_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .crc_o  (crc)
  );

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;

  // While the sequencer is busy, a symbol is produced whenever the output register is free or being emptied.
  assign step = (state_q != ST_IDLE) && (!out_valid_q || sym_o.ready);

  assign bit_w      = shreg_q[0];
  assign ones_inc   = (ones_q == RUN_MAX) ? ones_q : ones_q + 3'd1;
  assign need_stuff = bit_w && stuffing_q && (ones_inc == STUFF_LIMIT);

  always_comb begin
    state_d    = state_q;
    shreg_d    = shreg_q;
    rem_d      = rem_q;
    stuffing_d = stuffing_q;
    ones_d     = ones_q;
    level_d    = level_q;
    tone_d     = tone_q;
    stuff_d    = stuff_q;
    last_d     = last_q;
    crc_ctl    = '{init: 1'b0, shift: 1'b0, data: bit_w};

    if (sym_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i.cmd))
            CMD_STUFFED, CMD_FLAG: begin
              shreg_d    = {8'h00, cmd_i.data_byte};
              rem_d      = BYTE_BITS;
              stuffing_d = (cmd_e'(cmd_i.cmd) == CMD_STUFFED);
              state_d    = ST_DATA;
            end
            CMD_START: begin
              crc_ctl.init = 1'b1;
            end
            CMD_FCS: begin
              shreg_d    = ~crc;
              rem_d      = FCS_BITS;
              stuffing_d = 1'b1;
              state_d    = ST_DATA;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DATA: begin
        if (step) begin
          crc_ctl.shift = 1'b1;
          shreg_d       = shreg_q >> 1;
          rem_d         = rem_q - 5'd1;
          level_d       = bit_w ? level_q : ~level_q;
          ones_d        = need_stuff ? 3'd0 : (bit_w ? ones_inc : 3'd0);
          out_valid_d   = 1'b1;
          tone_d        = level_d;
          stuff_d       = 1'b0;
          last_d        = (rem_q == 5'd1) && !need_stuff;
          if (need_stuff) begin
            state_d = ST_STUFF;
          end else if (rem_q == 5'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STUFF: begin
        if (step) begin
          level_d     = ~level_q;
          out_valid_d = 1'b1;
          tone_d      = level_d;
          stuff_d     = 1'b1;
          last_d      = (rem_q == 5'd0);
          state_d     = (rem_q == 5'd0) ? ST_IDLE : ST_DATA;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ones_q      <= 3'd0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
      stuffing_q  <= 1'b0;
      rem_q       <= 5'd0;
    end else begin
      state_q     <= state_d;
      ones_q      <= ones_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
      stuffing_q  <= stuffing_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    tone_q  <= tone_d;
    stuff_q <= stuff_d;
    last_q  <= last_d;
  end

  assign sym_o.valid    = out_valid_q;
  assign sym_o.tone     = tone_q;
  assign sym_o.is_stuff = stuff_q;
  assign sym_o.last     = last_q;

`ifndef SYNTHESIS
  // A pending stuff symbol always follows a cleared run of ones.
  a_stuff_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stuff_q) |-> (ones_q == 3'd0))
    else $error("stuff symbol pending with nonzero ones run");

  // Stuff bits are only inserted on stuffed bytes.
  a_stuff_only_when_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STUFF) |-> stuffing_q)
    else $error("stuff state entered with stuffing off");

  // The sequencer returns to idle right after the symbol marked last.
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last_d) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after last symbol");

  // A frame start leaves the CRC at its initial value.
  a_start_inits_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_e'(cmd_i.cmd) == CMD_START)) |=> (crc == CRC_INIT))
    else $error("CRC not initialized by frame start");
`endif

endmodule
